// ===== rtl/core/ilfr_pkg.sv =====
// Types and constants shared by the instrument link frame receiver modules.
package ilfr_pkg;

  // Link control characters.
  localparam logic [7:0] CH_SOH   = 8'd1;
  localparam logic [7:0] CH_STX   = 8'd2;
  localparam logic [7:0] CH_ETX   = 8'd3;
  localparam logic [7:0] CH_EOT   = 8'd4;
  localparam logic [7:0] CH_ENQ   = 8'd5;
  localparam logic [7:0] CH_ACK   = 8'd6;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_W     = 8'h57;
  localparam logic [7:0] CH_P     = 8'h50;

  // Error codes reported in error_code.
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_TIMEOUT  = 3'd1;
  localparam logic [2:0] ERR_BADREPLY = 3'd2;
  localparam logic [2:0] ERR_SOH      = 3'd3;
  localparam logic [2:0] ERR_TYPE     = 3'd4;
  localparam logic [2:0] ERR_STX      = 3'd5;
  localparam logic [2:0] ERR_ETX      = 3'd6;
  localparam logic [2:0] ERR_OVERFLOW = 3'd7;

  // Configuration register indexes.
  localparam logic [2:0] CFG_REQUEST_RBC     = 3'd0;
  localparam logic [2:0] CFG_REQUEST_WBC     = 3'd1;
  localparam logic [2:0] CFG_REQUEST_PLT     = 3'd2;
  localparam logic [2:0] CFG_CONNECT_TIMEOUT = 3'd3;
  localparam logic [2:0] CFG_BUFFER_LIMIT    = 3'd4;

  localparam logic [15:0] TIMEOUT_RESET = 16'd10000;
  localparam logic [14:0] LIMIT_RESET   = 15'd16384;

  typedef enum logic [1:0] {
    CMD_BYTE       = 2'd0,
    CMD_TICK       = 2'd1,
    CMD_CONNECT    = 2'd2,
    CMD_DISCONNECT = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    LINK_IDLE       = 2'd0,
    LINK_CONNECTING = 2'd1,
    LINK_CONNECTED  = 2'd2,
    LINK_FAULT      = 2'd3
  } link_mode_t;

  typedef enum logic [2:0] {
    PKT_I = 3'd0,
    PKT_D = 3'd1,
    PKT_R = 3'd2,
    PKT_W = 3'd3,
    PKT_P = 3'd4
  } pkt_type_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        last;
    logic [1:0]  link_state;
    logic [2:0]  error_code;
    logic [15:0] package_count;
  } out_item_t;

  // Everything one input item answers with: one item (status only or a single byte) or a three byte reply.
  typedef struct packed {
    logic            tx_valid;
    logic            triple;
    logic [2:0][7:0] tx_bytes;
    logic [1:0]      link_state;
    logic [2:0]      error_code;
    logic [15:0]     package_count;
  } reply_t;

endpackage

// ===== rtl/core/ilfr_reply_queue.sv =====
// Two-entry reply queue that spreads each reply over one or three output items.
module ilfr_reply_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ilfr_pkg::reply_t    push_data,
  output logic                full,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output ilfr_pkg::out_item_t rsp_item
);
  import ilfr_pkg::*;

  reply_t     slots [2];
  logic       head;
  logic       tail;
  logic [1:0] count;
  logic [1:0] sub;
  reply_t     cur;
  logic       last_item;
  logic       pop;

  assign cur       = slots[head];
  assign last_item = !cur.triple || (sub == 2'd2);
  assign rsp_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign pop       = rsp_valid && !rsp_stall && last_item;

  always_comb begin
    rsp_item.tx_valid      = cur.tx_valid;
    rsp_item.tx_byte       = cur.tx_bytes[sub];
    rsp_item.last          = last_item;
    rsp_item.link_state    = cur.link_state;
    rsp_item.error_code    = cur.error_code;
    rsp_item.package_count = cur.package_count;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      tail  <= 1'b0;
      count <= 2'd0;
      sub   <= 2'd0;
    end else begin
      if (push) begin
        tail <= ~tail;
      end
      if (pop) begin
        head <= ~head;
        sub  <= 2'd0;
      end else if (rsp_valid && !rsp_stall) begin
        sub <= sub + 2'd1;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/core/instrument_link_frame_receiver_core.sv =====
// Top level of the instrument link frame receiver: link state, package checks, replies.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_item (cmd, rx_byte)
//   rsp      out        rsp_valid/rsp_stall   rsp_item (tx byte and link status)
//   cfg      in         cfg_we                cfg_index, cfg_data
//
// One item is accepted per cycle while req_stall is low. Its whole effect on the link
// state is computed in the cycle it is accepted, and its reply is written into a
// two-entry queue. A reply is one output item, or three items for the acknowledge of
// a good package, so the output port, one item per cycle while rsp_stall is low, sets
// the pace. req_stall is high only while both queue entries are taken; it is decoded
// from the queue count register only. Reset is synchronous and clears the link state,
// the counters and the queue, and returns the configuration registers to their defaults.
module instrument_link_frame_receiver_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  ilfr_pkg::in_item_t  req_item,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output ilfr_pkg::out_item_t rsp_item,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import ilfr_pkg::*;

  // Configuration registers.
  logic        request_rbc;
  logic        request_wbc;
  logic        request_plt;
  logic [15:0] connect_timeout;
  logic [14:0] buffer_limit;

  // Link and package state.
  link_mode_t  link_mode,      link_mode_next;
  logic [2:0]  last_error,     last_error_next;
  logic [15:0] wait_ticks,     wait_ticks_next;
  logic [14:0] byte_position,  byte_position_next;
  logic [7:0]  message_id,     message_id_next;
  pkt_type_t   package_type,   package_type_next;
  logic        end_text_seen,  end_text_seen_next;
  logic [2:0]  pending_error,  pending_error_next;
  logic [15:0] valid_packages, valid_packages_next;

  logic        accept;
  logic        queue_full;
  cmd_t        cmd;
  logic [7:0]  rx;
  reply_t      reply;
  logic        send_enq;
  logic        send_ack;
  logic        fail;
  logic [2:0]  fail_code;
  logic [7:0]  letter;
  logic [15:0] ticks_inc;

  assign req_stall = queue_full;
  assign accept    = req_valid && !req_stall;
  assign cmd       = cmd_t'(req_item.cmd);
  assign rx        = req_item.rx_byte;
  assign ticks_inc = wait_ticks + 16'd1;

  // Next state for the accepted item. A failure goes to the fault state and drops the
  // package in progress, whatever caused it.
  always_comb begin
    link_mode_next      = link_mode;
    last_error_next     = last_error;
    wait_ticks_next     = wait_ticks;
    byte_position_next  = byte_position;
    message_id_next     = message_id;
    package_type_next   = package_type;
    end_text_seen_next  = end_text_seen;
    pending_error_next  = pending_error;
    valid_packages_next = valid_packages;
    send_enq            = 1'b0;
    send_ack            = 1'b0;
    fail                = 1'b0;
    fail_code           = ERR_NONE;
    letter              = CH_SPACE;

    unique case (cmd)
      CMD_CONNECT: begin
        if (link_mode == LINK_IDLE || link_mode == LINK_FAULT) begin
          link_mode_next     = LINK_CONNECTING;
          last_error_next    = ERR_NONE;
          wait_ticks_next    = 16'd0;
          byte_position_next = 15'd0;
          message_id_next    = 8'd0;
          package_type_next  = PKT_I;
          end_text_seen_next = 1'b0;
          pending_error_next = ERR_NONE;
          send_enq           = 1'b1;
        end
      end
      CMD_DISCONNECT: begin
        link_mode_next     = LINK_IDLE;
        wait_ticks_next    = 16'd0;
        byte_position_next = 15'd0;
        message_id_next    = 8'd0;
        package_type_next  = PKT_I;
        end_text_seen_next = 1'b0;
        pending_error_next = ERR_NONE;
      end
      CMD_TICK: begin
        if (link_mode == LINK_CONNECTING) begin
          wait_ticks_next = ticks_inc;
          if (ticks_inc >= connect_timeout) begin
            fail      = 1'b1;
            fail_code = ERR_TIMEOUT;
          end
        end
      end
      CMD_BYTE: begin
        if (link_mode == LINK_CONNECTING) begin
          if (rx == CH_ACK) begin
            link_mode_next     = LINK_CONNECTED;
            byte_position_next = 15'd0;
            message_id_next    = 8'd0;
            package_type_next  = PKT_I;
            end_text_seen_next = 1'b0;
            pending_error_next = ERR_NONE;
          end else begin
            fail      = 1'b1;
            fail_code = ERR_BADREPLY;
          end
        end else if (link_mode == LINK_CONNECTED) begin
          if (byte_position >= buffer_limit) begin
            fail      = 1'b1;
            fail_code = ERR_OVERFLOW;
          end else begin
            // Only the first header error of a package is kept; it is reported at EOT.
            if (pending_error == ERR_NONE) begin
              if (rx == CH_EOT && byte_position >= 15'd1 && byte_position <= 15'd3) begin
                pending_error_next = ERR_STX;
              end else if (byte_position == 15'd0) begin
                if (rx != CH_SOH) begin
                  pending_error_next = ERR_SOH;
                end
              end else if (byte_position == 15'd1) begin
                message_id_next = rx;
              end else if (byte_position == 15'd2) begin
                unique case (rx)
                  CH_I:    package_type_next = PKT_I;
                  CH_D:    package_type_next = PKT_D;
                  CH_R:    package_type_next = PKT_R;
                  CH_W:    package_type_next = PKT_W;
                  CH_P:    package_type_next = PKT_P;
                  default: pending_error_next = ERR_TYPE;
                endcase
              end else if (byte_position == 15'd3) begin
                if (rx != CH_STX) begin
                  pending_error_next = ERR_STX;
                end
              end else if (rx == CH_ETX) begin
                end_text_seen_next = 1'b1;
              end
            end
            byte_position_next = byte_position + 15'd1;
            if (rx == CH_EOT) begin
              if (pending_error_next != ERR_NONE) begin
                fail      = 1'b1;
                fail_code = pending_error_next;
              end else if (!end_text_seen_next) begin
                fail      = 1'b1;
                fail_code = ERR_ETX;
              end else begin
                send_ack            = 1'b1;
                valid_packages_next = valid_packages + 16'd1;
                byte_position_next  = 15'd0;
                message_id_next     = 8'd0;
                package_type_next   = PKT_I;
                end_text_seen_next  = 1'b0;
                pending_error_next  = ERR_NONE;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase

    if (fail) begin
      link_mode_next     = LINK_FAULT;
      last_error_next    = fail_code;
      byte_position_next = 15'd0;
      message_id_next    = 8'd0;
      package_type_next  = PKT_I;
      end_text_seen_next = 1'b0;
      pending_error_next = ERR_NONE;
    end

    // The request letter follows the type of the package just acknowledged. An EOT that
    // is acknowledged comes after the header, so the type and the message id still sit
    // in their registers while the next values are already cleared.
    unique case (package_type)
      PKT_D:   letter = request_rbc ? CH_R : CH_SPACE;
      PKT_R:   letter = request_wbc ? CH_W : CH_SPACE;
      PKT_W:   letter = request_plt ? CH_P : CH_SPACE;
      default: letter = CH_SPACE;
    endcase

    reply.tx_valid      = send_enq || send_ack;
    reply.triple        = send_ack;
    reply.tx_bytes[0]   = send_ack ? CH_ACK : (send_enq ? CH_ENQ : 8'd0);
    reply.tx_bytes[1]   = letter;
    reply.tx_bytes[2]   = message_id;
    reply.link_state    = link_mode_next;
    reply.error_code    = last_error_next;
    reply.package_count = valid_packages_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      request_rbc     <= 1'b0;
      request_wbc     <= 1'b0;
      request_plt     <= 1'b0;
      connect_timeout <= TIMEOUT_RESET;
      buffer_limit    <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REQUEST_RBC:     request_rbc     <= cfg_data[0];
        CFG_REQUEST_WBC:     request_wbc     <= cfg_data[0];
        CFG_REQUEST_PLT:     request_plt     <= cfg_data[0];
        CFG_CONNECT_TIMEOUT: connect_timeout <= cfg_data;
        CFG_BUFFER_LIMIT:    buffer_limit    <= cfg_data[14:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_mode      <= LINK_IDLE;
      last_error     <= ERR_NONE;
      wait_ticks     <= 16'd0;
      byte_position  <= 15'd0;
      message_id     <= 8'd0;
      package_type   <= PKT_I;
      end_text_seen  <= 1'b0;
      pending_error  <= ERR_NONE;
      valid_packages <= 16'd0;
    end else if (accept) begin
      link_mode      <= link_mode_next;
      last_error     <= last_error_next;
      wait_ticks     <= wait_ticks_next;
      byte_position  <= byte_position_next;
      message_id     <= message_id_next;
      package_type   <= package_type_next;
      end_text_seen  <= end_text_seen_next;
      pending_error  <= pending_error_next;
      valid_packages <= valid_packages_next;
    end
  end

  ilfr_reply_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (reply),
    .full      (queue_full),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item)
  );

`ifndef NO_ASSERTIONS
  // A connect from the idle state always starts the handshake.
  a_connect_starts: assert property (@(posedge clk) disable iff (rst)
    accept && cmd == CMD_CONNECT && link_mode == LINK_IDLE |=> link_mode == LINK_CONNECTING)
    else $error("connect from idle did not enter connecting");

  // Package bookkeeping only lives while the link is connected.
  a_package_scope: assert property (@(posedge clk) disable iff (rst)
    (pending_error != ERR_NONE || byte_position != 15'd0) |-> link_mode == LINK_CONNECTED)
    else $error("package state outside a connected link");

  // A session in progress carries no error.
  a_session_clean: assert property (@(posedge clk) disable iff (rst)
    (link_mode == LINK_CONNECTING || link_mode == LINK_CONNECTED) |-> last_error == ERR_NONE)
    else $error("error code set during a live session");

  // An item without a byte to send is always the only item of its reply.
  a_status_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_item.tx_valid |-> rsp_item.last)
    else $error("status item not marked last");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the instrument link frame receiver with random link sessions.
module tb;
  import ilfr_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 430;
  localparam int PHASES       = 8;

  // Mirrors the link state and the configuration, and holds the replies still owed.
  class link_scoreboard;
    bit          ask_rbc;
    bit          ask_wbc;
    bit          ask_plt;
    logic [15:0] timeout_ticks;
    logic [14:0] length_limit;

    link_mode_t  mode;
    logic [2:0]  last_err;
    logic [15:0] ticks_waited;
    logic [14:0] pos;
    logic [7:0]  msg_id;
    pkt_type_t   ptype;
    bit          etx_seen;
    logic [2:0]  held_err;
    logic [15:0] acked_packages;

    out_item_t   replies_q[$];
    int          mismatches;

    function new();
      reset_state();
      mismatches = 0;
    endfunction

    function void clear_package();
      pos      = '0;
      msg_id   = '0;
      ptype    = PKT_I;
      etx_seen = 1'b0;
      held_err = ERR_NONE;
    endfunction

    function void reset_state();
      ask_rbc        = 1'b0;
      ask_wbc        = 1'b0;
      ask_plt        = 1'b0;
      timeout_ticks  = TIMEOUT_RESET;
      length_limit   = LIMIT_RESET;
      mode           = LINK_IDLE;
      last_err       = ERR_NONE;
      ticks_waited   = '0;
      acked_packages = '0;
      clear_package();
      replies_q.delete();
    endfunction

    function void enter_fault(logic [2:0] code);
      mode     = LINK_FAULT;
      last_err = code;
      clear_package();
    endfunction

    function void write_register(logic [2:0] idx, logic [15:0] data);
      case (idx)
        CFG_REQUEST_RBC:     ask_rbc = data[0];
        CFG_REQUEST_WBC:     ask_wbc = data[0];
        CFG_REQUEST_PLT:     ask_plt = data[0];
        CFG_CONNECT_TIMEOUT: timeout_ticks = data;
        CFG_BUFFER_LIMIT:    length_limit = data[14:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] reply_letter();
      case (ptype)
        PKT_D:   return ask_rbc ? CH_R : CH_SPACE;
        PKT_R:   return ask_wbc ? CH_W : CH_SPACE;
        PKT_W:   return ask_plt ? CH_P : CH_SPACE;
        default: return CH_SPACE;
      endcase
    endfunction

    // One byte of a package while connected; returns 1 when the package is to be acknowledged.
    function bit package_byte(logic [7:0] b);
      if (pos >= length_limit) begin
        enter_fault(ERR_OVERFLOW);
        return 1'b0;
      end
      // Only the first header error of a package is kept.
      if (held_err == ERR_NONE) begin
        if (b == CH_EOT && pos >= 15'd1 && pos <= 15'd3) begin
          held_err = ERR_STX;
        end else if (pos == 15'd0) begin
          if (b != CH_SOH) held_err = ERR_SOH;
        end else if (pos == 15'd1) begin
          msg_id = b;
        end else if (pos == 15'd2) begin
          case (b)
            CH_I:    ptype = PKT_I;
            CH_D:    ptype = PKT_D;
            CH_R:    ptype = PKT_R;
            CH_W:    ptype = PKT_W;
            CH_P:    ptype = PKT_P;
            default: held_err = ERR_TYPE;
          endcase
        end else if (pos == 15'd3) begin
          if (b != CH_STX) held_err = ERR_STX;
        end else if (b == CH_ETX) begin
          etx_seen = 1'b1;
        end
      end
      pos = pos + 15'd1;
      if (b != CH_EOT) return 1'b0;
      if (held_err != ERR_NONE) begin
        enter_fault(held_err);
        return 1'b0;
      end
      if (!etx_seen) begin
        enter_fault(ERR_ETX);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    // Called for every accepted input item: updates the state and queues its replies.
    function void note_input(in_item_t it);
      logic [7:0] tx_bytes[3];
      int         n;
      int         k;
      out_item_t  r;
      n = 0;
      case (it.cmd)
        CMD_CONNECT: begin
          if (mode == LINK_IDLE || mode == LINK_FAULT) begin
            mode         = LINK_CONNECTING;
            last_err     = ERR_NONE;
            ticks_waited = '0;
            clear_package();
            tx_bytes[0]  = CH_ENQ;
            n            = 1;
          end
        end
        CMD_DISCONNECT: begin
          mode         = LINK_IDLE;
          ticks_waited = '0;
          clear_package();
        end
        CMD_TICK: begin
          if (mode == LINK_CONNECTING) begin
            ticks_waited = ticks_waited + 16'd1;
            if (ticks_waited >= timeout_ticks) enter_fault(ERR_TIMEOUT);
          end
        end
        default: begin
          if (mode == LINK_CONNECTING) begin
            if (it.rx_byte == CH_ACK) begin
              mode = LINK_CONNECTED;
              clear_package();
            end else begin
              enter_fault(ERR_BADREPLY);
            end
          end else if (mode == LINK_CONNECTED && package_byte(it.rx_byte)) begin
            tx_bytes[0]    = CH_ACK;
            tx_bytes[1]    = reply_letter();
            tx_bytes[2]    = msg_id;
            n              = 3;
            acked_packages = acked_packages + 16'd1;
            clear_package();
          end
        end
      endcase

      // Every reply item carries the status after the whole input was handled.
      r               = '0;
      r.link_state    = mode;
      r.error_code    = last_err;
      r.package_count = acked_packages;
      if (n == 0) begin
        r.last = 1'b1;
        replies_q.push_back(r);
      end else begin
        for (k = 0; k < n; k++) begin
          r.tx_valid = 1'b1;
          r.tx_byte  = tx_bytes[k];
          r.last     = (k == n - 1);
          replies_q.push_back(r);
        end
      end
    endfunction

    task report(string what);
      mismatches++;
      $display("tb: mismatch: %s", what);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (replies_q.size() == 0) begin
        report($sformatf("result %h with nothing expected", got));
        return;
      end
      want = replies_q.pop_front();
      if (got.tx_valid !== want.tx_valid)
        report($sformatf("tx_valid %b, expected %b", got.tx_valid, want.tx_valid));
      if (got.tx_byte !== want.tx_byte)
        report($sformatf("tx_byte %h, expected %h", got.tx_byte, want.tx_byte));
      if (got.last !== want.last)
        report($sformatf("last %b, expected %b", got.last, want.last));
      if (got.link_state !== want.link_state)
        report($sformatf("link_state %0d, expected %0d", got.link_state, want.link_state));
      if (got.error_code !== want.error_code)
        report($sformatf("error_code %0d, expected %0d", got.error_code, want.error_code));
      if (got.package_count !== want.package_count)
        report($sformatf("package_count %0d, expected %0d", got.package_count,
                         want.package_count));
    endtask

    function int pending();
      return replies_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  in_item_t    req_item  = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  out_item_t   rsp_item;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  link_scoreboard sb = new();

  int items_sent = 0;
  int idle_pct   = 17;
  int stall_pct  = 77;
  int cycles     = 0;

  instrument_link_frame_receiver_core uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_item  (req_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Both handshakes are sampled in one process, so an item is predicted before any result
  // of the same edge is checked.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) sb.note_input(req_item);
      if (rsp_valid && !rsp_stall) sb.check_result(rsp_item);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Sender idles first lightly against a slow receiver, then the reverse, then neither.
  function void pick_idling();
    if (items_sent < 150) begin
      idle_pct  = 17;
      stall_pct = 77;
    end else if (items_sent < 300) begin
      idle_pct  = 77;
      stall_pct = 17;
    end else begin
      idle_pct  = 0;
      stall_pct = 0;
    end
  endfunction

  task send_item(cmd_t c, logic [7:0] b);
    int       gap;
    in_item_t it;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    it.cmd     = c;
    it.rx_byte = b;
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req_item  <= it;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    items_sent++;
    pick_idling();
  endtask

  task send_byte(logic [7:0] b);
    send_item(CMD_BYTE, b);
  endtask

  // Drops valid and waits until every owed reply has come out.
  task wait_drained();
    @(negedge clk);
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task put_register(logic [2:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_register(idx, data);
  endtask

  task write_config(bit rbc, bit wbc, bit plt, logic [15:0] tmo, logic [14:0] lim);
    wait_drained();
    put_register(CFG_REQUEST_RBC, {15'd0, rbc});
    put_register(CFG_REQUEST_WBC, {15'd0, wbc});
    put_register(CFG_REQUEST_PLT, {15'd0, plt});
    put_register(CFG_CONNECT_TIMEOUT, tmo);
    put_register(CFG_BUFFER_LIMIT, {1'b0, lim});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function logic [7:0] payload_byte(bit allow_etx);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_EOT || (!allow_etx && b == CH_ETX));
    return b;
  endfunction

  function logic [7:0] type_letter();
    case ($urandom_range(0, 4))
      0:       return CH_I;
      1:       return CH_D;
      2:       return CH_R;
      3:       return CH_W;
      default: return CH_P;
    endcase
  endfunction

  function logic [7:0] not_a_letter();
    logic [7:0] b;
    do b = payload_byte(1'b1);
    while (b inside {CH_I, CH_D, CH_R, CH_W, CH_P});
    return b;
  endfunction

  task send_header(logic [7:0] type_byte);
    send_byte(CH_SOH);
    send_byte(payload_byte(1'b1));
    send_byte(type_byte);
    send_byte(CH_STX);
  endtask

  // One package: mostly well formed, otherwise one of the ways a package can be broken.
  task send_package();
    int         kind;
    int         fill;
    logic [7:0] b;
    kind = $urandom_range(0, 19);
    if (kind <= 12) begin
      send_header(type_letter());
      repeat ($urandom_range(0, 3)) send_byte(payload_byte(1'b1));
      send_byte(CH_ETX);
      repeat ($urandom_range(0, 2)) send_byte(payload_byte(1'b1));
      send_byte(CH_EOT);
    end else if (kind == 13) begin
      // Length right at the buffer limit, one short of it, or one over, when the limit is at most 40.
      fill = 0;
      if (sb.length_limit <= 40) fill = sb.length_limit + $urandom_range(0, 2) - 7;
      send_header(type_letter());
      repeat (fill) send_byte(payload_byte(1'b1));
      send_byte(CH_ETX);
      send_byte(CH_EOT);
    end else if (kind == 14) begin
      do b = 8'($urandom_range(0, 255));
      while (b == CH_SOH);
      send_byte(b);
      if (b != CH_EOT) begin
        send_byte(payload_byte(1'b1));
        send_byte(CH_EOT);
      end
    end else if (kind == 15) begin
      send_header(not_a_letter());
      send_byte(CH_ETX);
      send_byte(CH_EOT);
    end else if (kind == 16) begin
      send_byte(CH_SOH);
      send_byte(payload_byte(1'b1));
      send_byte(type_letter());
      do b = payload_byte(1'b1);
      while (b == CH_STX);
      send_byte(b);
      send_byte(CH_ETX);
      send_byte(CH_EOT);
    end else if (kind == 17) begin
      send_header(type_letter());
      repeat ($urandom_range(0, 3)) send_byte(payload_byte(1'b0));
      send_byte(CH_EOT);
    end else if (kind == 18) begin
      // Package that ends before its STX.
      send_byte(CH_SOH);
      repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
      send_byte(CH_EOT);
    end else begin
      repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
      send_byte(CH_EOT);
    end
  endtask

  // Connect, sometimes send a few ticks, usually answer the ENQ, then a handful of packages.
  task run_session();
    int npk;
    int i;
    send_item(CMD_CONNECT, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 9) < 3)
      repeat ($urandom_range(1, 4)) send_item(CMD_TICK, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 9) != 0) send_byte(CH_ACK);
    else send_byte(8'($urandom_range(0, 255)));
    npk = $urandom_range(1, 4);
    for (i = 0; i < npk && sb.mode == LINK_CONNECTED; i++) begin
      if ($urandom_range(0, 9) == 0) send_item(CMD_TICK, 8'($urandom_range(0, 255)));
      send_package();
    end
    if ($urandom_range(0, 3) == 0) send_item(CMD_DISCONNECT, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int p;
    int phase_end;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part under the reset configuration.
    send_byte(CH_ACK);                      // byte while not connected is ignored
    send_item(CMD_TICK, 8'hFF);             // tick while not connected is ignored
    send_item(CMD_DISCONNECT, 8'h00);
    send_item(CMD_CONNECT, 8'h00);          // ENQ goes out
    send_item(CMD_CONNECT, 8'hFF);          // already connecting, nothing sent
    send_item(CMD_TICK, 8'h00);
    send_byte(CH_ACK);
    send_item(CMD_TICK, 8'h00);             // tick while connected is ignored
    send_byte(CH_SOH);
    send_byte(8'hFF);
    send_byte(CH_D);
    send_byte(CH_STX);
    send_byte(CH_ETX);
    send_byte(CH_EOT);                      // good package, acknowledged
    send_byte(CH_SOH);
    send_byte(CH_EOT);                      // short package gives a STX error
    send_item(CMD_CONNECT, 8'h00);
    send_byte(CH_ACK);
    send_byte(CH_EOT);                      // EOT as first byte gives a SOH error
    send_item(CMD_CONNECT, 8'h00);
    send_byte(8'h00);                       // wrong reply to ENQ
    send_item(CMD_DISCONNECT, 8'hFF);       // error code is kept
    send_item(CMD_CONNECT, 8'h00);
    send_item(CMD_TICK, 8'h00);

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0:       write_config(1'b1, 1'b1, 1'b1, 16'd0, 15'd8);
        1:       write_config(1'b0, 1'b0, 1'b0, 16'd1, 15'd16384);
        2:       write_config(1'b1, 1'b0, 1'b1, 16'hFFFF, 15'h7FFF);
        3:       write_config(1'b0, 1'b1, 1'b0, 16'd3, 15'd12);
        default: write_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 16'($urandom_range(0, 6)),
                              15'($urandom_range(8, 30)));
      endcase
      // Phase ends are fixed points of the whole run, so overshoot does not pile up.
      phase_end = (p + 1) * RANDOM_ITEMS / PHASES;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 4) != 0) run_session();
        else repeat ($urandom_range(1, 4))
          send_item(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end

    wait_drained();
    repeat (16) @(posedge clk);
    if (sb.mismatches == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
